@@ rtl/ffba_pkg.sv @@
package ffba_pkg;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] req_size;
    logic [6:0] req_start;
  } req_t;

  typedef struct packed {
    logic       status;
    logic [6:0] alloc_start;
    logic [7:0] free_total;
    logic [7:0] largest_free_run;
  } res_t;

  typedef struct packed {
    logic clear;
    logic valid;
    logic free_bit;
  } scan_ctl_t;

endpackage

@@ rtl/first_fit_bitmap_allocator.sv @@
// channel   ports                      handshake
// request   start, busy, req (req_t)   taken when start is high and busy is low
// result    done, res (res_t)          valid for the single cycle done is high
//
// one map unit is read per cycle from a single-bit ram by one shared run counter
// allocate: first-fit search pass, then update pass
// every request: update/statistics pass over the whole map
// after reset the map is swept to free with busy high
// results cannot be stalled; done pulses once per request
module first_fit_bitmap_allocator import ffba_pkg::*; #(
  parameter int HEAP_UNITS = 128
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output res_t res
);

  localparam int AW = $clog2(HEAP_UNITS);
  localparam int CW = $clog2(HEAP_UNITS + 1);
  localparam int RW = AW + 10;
  localparam logic [AW-1:0] LAST = AW'(HEAP_UNITS - 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

  state_t        state;
  req_t          op;
  logic          issuing;
  logic [AW-1:0] ctr;
  logic          pend;
  logic [AW-1:0] pidx;
  logic          emit;
  logic          found;
  logic [AW-1:0] grant;

  logic          re;
  logic [0:0]    rdata;
  logic          new_bit;
  logic          in_rng;
  logic [RW-1:0] idx_w;
  logic [RW-1:0] lo_w;
  logic [RW-1:0] hi_w;
  logic          search_end;
  scan_ctl_t     sctl;
  logic          hit;
  logic [AW-1:0] hit_begin;
  logic [CW-1:0] free_next;
  logic [CW-1:0] best_next;
  logic [AW+6:0] grant_ext;
  logic [CW+7:0] free_ext;
  logic [CW+7:0] best_ext;
  res_t          res_next;

  assign busy = (state != S_IDLE);
  assign re   = issuing && (state != S_IDLE);

  ffba_ram #(.WIDTH(1), .DEPTH(HEAP_UNITS)) u_map (
    .clk   (clk),
    .we    (pend && (state == S_UPDATE)),
    .waddr (pidx),
    .wdata (new_bit),
    .re    (re),
    .raddr (ctr),
    .rdata (rdata)
  );

  // range check for the freed or granted run
  assign idx_w  = RW'(pidx);
  assign lo_w   = (op.kind == KIND_FREE) ? RW'(op.req_start) : RW'(grant);
  assign hi_w   = lo_w + RW'(op.req_size);
  assign in_rng = (idx_w >= lo_w) && (idx_w < hi_w);

  always_comb begin
    case (op.kind)
      KIND_ALLOC: new_bit = rdata[0] | (found & in_rng);
      KIND_FREE:  new_bit = rdata[0] & ~in_rng;
      KIND_CLEAR: new_bit = 1'b0;
      default:    new_bit = rdata[0];
    endcase
  end

  assign search_end = (state == S_SEARCH) && pend && (hit || (pidx == LAST));

  assign sctl.clear    = ((state == S_IDLE) && start) || search_end;
  assign sctl.valid    = pend && (state != S_IDLE);
  assign sctl.free_bit = (state == S_SEARCH) ? ~rdata[0] : ~new_bit;

  ffba_scan #(.HEAP_UNITS(HEAP_UNITS)) u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctl       (sctl),
    .idx       (pidx),
    .size      (op.req_size),
    .hit       (hit),
    .hit_begin (hit_begin),
    .free_next (free_next),
    .best_next (best_next)
  );

  assign grant_ext = {7'b0, grant};
  assign free_ext  = {8'b0, free_next};
  assign best_ext  = {8'b0, best_next};

  always_comb begin
    res_next.status           = (op.kind == KIND_ALLOC) && !found;
    res_next.alloc_start      = found ? grant_ext[6:0] : 7'd0;
    res_next.free_total       = free_ext[7:0];
    res_next.largest_free_run = best_ext[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_UPDATE;
      op      <= '{kind: KIND_CLEAR, default: '0};
      issuing <= 1'b1;
      ctr     <= '0;
      pend    <= 1'b0;
      emit    <= 1'b0;
      found   <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      pend <= re;
      pidx <= ctr;
      if (re) begin
        if (ctr == LAST) begin
          issuing <= 1'b0;
        end else begin
          ctr <= ctr + AW'(1);
        end
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            op      <= req;
            emit    <= 1'b1;
            found   <= 1'b0;
            ctr     <= '0;
            issuing <= 1'b1;
            if ((req.kind == KIND_ALLOC) && (req.req_size != 8'd0)) begin
              state <= S_SEARCH;
            end else begin
              state <= S_UPDATE;
            end
          end
        end
        S_SEARCH: begin
          if (search_end) begin
            found   <= hit;
            grant   <= hit_begin;
            state   <= S_UPDATE;
            ctr     <= '0;
            issuing <= 1'b1;
            pend    <= 1'b0;
          end
        end
        S_UPDATE: begin
          if (pend && (pidx == LAST)) begin
            state <= S_IDLE;
            done  <= emit;
            res   <= res_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/ffba_ram.sv @@
module ffba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/ffba_scan.sv @@
module ffba_scan import ffba_pkg::*; #(
  parameter int HEAP_UNITS = 128,
  localparam int AW = $clog2(HEAP_UNITS),
  localparam int CW = $clog2(HEAP_UNITS + 1),
  localparam int SW = (CW > 8) ? CW : 8
) (
  input  logic          clk,
  input  logic          rst,
  input  scan_ctl_t     ctl,
  input  logic [AW-1:0] idx,
  input  logic [7:0]    size,
  output logic          hit,
  output logic [AW-1:0] hit_begin,
  output logic [CW-1:0] free_next,
  output logic [CW-1:0] best_next
);

  logic [CW-1:0] run;
  logic [CW-1:0] run_next;
  logic [CW-1:0] fcnt;
  logic [CW-1:0] best;
  logic [AW-1:0] beg;

  assign run_next  = ctl.free_bit ? run + CW'(1) : '0;
  assign free_next = fcnt + CW'(ctl.free_bit);
  assign best_next = (run_next > best) ? run_next : best;
  assign hit_begin = (run == '0) ? idx : beg;
  assign hit       = ctl.valid && ctl.free_bit && (SW'(run_next) == SW'(size));

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      run  <= '0;
      fcnt <= '0;
      best <= '0;
      beg  <= '0;
    end else if (ctl.valid) begin
      run  <= run_next;
      fcnt <= free_next;
      best <= best_next;
      beg  <= hit_begin;
    end
  end

endmodule

@@ rtl/ffba_chk.sv @@
module ffba_chk import ffba_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input res_t res
);

  a_reset_sweep: assert property (@(posedge clk) $fell(rst) |-> busy)
    else $error("map sweep not running after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("item accepted but block not busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result while still busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  a_fail_start: assert property (@(posedge clk) disable iff (rst)
    done && res.status |-> res.alloc_start == 7'd0)
    else $error("failed allocate reports a start");

endmodule

bind first_fit_bitmap_allocator ffba_chk u_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .res   (res)
);

@@ tb/first_fit_bitmap_allocator_test.sv @@
`timescale 1ns / 100ps

module first_fit_bitmap_allocator_test;
  import ffba_pkg::*;

  localparam int UNITS = 128;
  localparam int ITEMS = 700;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 2 * UNITS + 10;

  localparam logic [1:0] KIND_NOP = 2'd3;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_NO_ROOM = 1'b1;

  class alloc_scoreboard;
    bit [UNITS-1:0] used_units;
    res_t pending_res[$];
    int errors;

    function new();
      used_units = '0;
      errors = 0;
    endfunction

    // apply one accepted item to the shadow map and queue its result
    function void note_request(req_t r);
      res_t e;
      int run;
      int first_u;
      int lim;
      int free_count;
      int best;
      bit granted;
      e = '0;
      run = 0;
      first_u = 0;
      granted = 1'b0;
      case (r.kind)
        KIND_ALLOC: begin
          e.status = STATUS_NO_ROOM;
          if (r.req_size != 0) begin
            for (int u = 0; u < UNITS; u++) begin
              if (!granted && !used_units[u]) begin
                if (run == 0) first_u = u;
                run++;
                if (run == int'(r.req_size)) begin
                  for (int k = first_u; k <= u; k++) used_units[k] = 1'b1;
                  granted = 1'b1;
                  e.status = STATUS_OK;
                  e.alloc_start = 7'(first_u);
                end
              end else begin
                run = 0;
              end
            end
          end
        end
        KIND_FREE: begin
          // clipped at the heap end
          lim = int'(r.req_start) + int'(r.req_size);
          if (lim > UNITS) lim = UNITS;
          for (int u = int'(r.req_start); u < lim; u++) used_units[u] = 1'b0;
        end
        KIND_CLEAR: used_units = '0;
        default: ;
      endcase
      free_count = 0;
      best = 0;
      run = 0;
      for (int u = 0; u < UNITS; u++) begin
        if (!used_units[u]) begin
          free_count++;
          run++;
          if (run > best) best = run;
        end else begin
          run = 0;
        end
      end
      e.free_total = 8'(free_count);
      e.largest_free_run = 8'(best);
      pending_res.push_back(e);
    endfunction

    function void compare_field(string name, int exp_val, int got_val);
      if (exp_val != got_val) begin
        $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_val, got_val);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t exp_res;
      if (pending_res.size() == 0) begin
        $display("%0t unexpected result expected none actual %h", $time, got);
        errors++;
        return;
      end
      exp_res = pending_res.pop_front();
      compare_field("status", exp_res.status, got.status);
      compare_field("alloc_start", exp_res.alloc_start, got.alloc_start);
      compare_field("free_total", exp_res.free_total, got.free_total);
      compare_field("largest_free_run", exp_res.largest_free_run, got.largest_free_run);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic done;
  res_t res;

  alloc_scoreboard sb;
  int cycle_count = 0;

  first_fit_bitmap_allocator #(
    .HEAP_UNITS(UNITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .res(res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(res);
  end

  function automatic req_t make_req(logic [1:0] kind, logic [7:0] size, logic [6:0] at);
    req_t r;
    r.kind = kind;
    r.req_size = size;
    r.req_start = at;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.req_start = 7'($urandom);
    if (pick < 55) begin
      r.kind = KIND_ALLOC;
      r.req_size = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 16));
    end else if (pick < 92) begin
      r.kind = KIND_FREE;
      r.req_size = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 24));
    end else if (pick < 96) begin
      r.kind = KIND_CLEAR;
      r.req_size = 8'($urandom);
    end else begin
      r.kind = KIND_NOP;
      r.req_size = 8'($urandom);
    end
    return r;
  endfunction

  // start stays high on return so back-to-back items need no extra edge
  task automatic send_item(req_t r);
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    sb.note_request(r);
  endtask

  task automatic pause_sender();
    int n;
    n = $urandom_range(1, 5);
    start <= 1'b0;
    req <= req_t'($urandom);
    // sometimes line the gap up with the end of the current item
    if ($urandom_range(0, 1) == 1) begin
      do @(posedge clk); while (busy);
    end
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending_res.size() != 0);
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // zero size, whole heap, full heap, clipped free, oversize
    send_item(make_req(KIND_ALLOC, 8'd0, 7'd0));
    send_item(make_req(KIND_ALLOC, 8'd128, 7'd127));
    send_item(make_req(KIND_ALLOC, 8'd1, 7'd0));
    send_item(make_req(KIND_FREE, 8'd255, 7'd0));
    send_item(make_req(KIND_ALLOC, 8'd200, 7'd0));
    send_item(make_req(KIND_ALLOC, 8'd129, 7'd0));
    // first fit into a hole, then zero-size free, no-op, clear and heap-end cases
    send_item(make_req(KIND_ALLOC, 8'd1, 7'd0));
    send_item(make_req(KIND_ALLOC, 8'd3, 7'd0));
    send_item(make_req(KIND_ALLOC, 8'd5, 7'd0));
    send_item(make_req(KIND_FREE, 8'd3, 7'd1));
    send_item(make_req(KIND_ALLOC, 8'd4, 7'd0));
    send_item(make_req(KIND_ALLOC, 8'd2, 7'd0));
    send_item(make_req(KIND_FREE, 8'd0, 7'd1));
    send_item(make_req(KIND_FREE, 8'd10, 7'd100));
    send_item(make_req(KIND_NOP, 8'd255, 7'd127));
    send_item(make_req(KIND_ALLOC, 8'd128, 7'd0));
    send_item(make_req(KIND_ALLOC, 8'd115, 7'd0));
    send_item(make_req(KIND_FREE, 8'd1, 7'd127));
    send_item(make_req(KIND_ALLOC, 8'd1, 7'd0));
    send_item(make_req(KIND_CLEAR, 8'd255, 7'd127));
    send_item(make_req(KIND_ALLOC, 8'd127, 7'd0));
    send_item(make_req(KIND_ALLOC, 8'd1, 7'd0));
    send_item(make_req(KIND_FREE, 8'd128, 7'd127));
    send_item(make_req(KIND_CLEAR, 8'd0, 7'd0));
    drain_results();

    for (int n = 0; n < ITEMS; n++) begin
      send_item(random_request());
      if (n % 150 == 149) drain_results();
      else if (n < ITEMS - 100 && $urandom_range(0, 3) == 0) pause_sender();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_res.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
